### rtl/acj_pkg.sv
// acj_pkg: shared constants and types of the audio crossfade joiner.
// Used by the datapath, the controller and the top level; depends on nothing.
package acj_pkg;

    // largest overlap the tail buffer can hold
    localparam int ACJ_MAX_FADE = 1024;
    localparam int ACJ_ADDR_W   = $clog2(ACJ_MAX_FADE);

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 24;
    localparam int FLEN_W   = 11;
    localparam int STEP_W   = 17;
    localparam int TDATA_W  = 64;
    localparam int TUSER_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 17;

    // ramp value 1.0 in Q1.16
    localparam logic [STEP_W-1:0] ONE_Q16 = 17'h10000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP   = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;          // capture the input request
        logic eval;             // commit positions, tail write, tail read, ramp
        logic mix_mult;         // register the ramp product
        logic load_out_direct;  // pass the sample through to the output
        logic load_out_mix;     // load the mixed sample to the output
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic drop;      // sample beyond its segment
        logic to_tail;   // sample goes into the tail buffer
        logic do_mix;    // sample is mixed with the held tail
        logic out_free;  // output register can take a new request
    } t_dp_status;

endpackage

### rtl/acj_ram.sv
// acj_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module acj_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/acj_dp.sv
// acj_dp: datapath of the crossfade joiner: request registers, segment
// positions, configuration, tail buffer, ramp multiplier and output register.
// Depends on acj_pkg and acj_ram.
module acj_dp
    import acj_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DAT_W-1:0]   i_cfg_data,
    // input request payload
    input  logic [TDATA_W-1:0]     i_tdata,
    input  logic [TUSER_W-1:0]     i_tuser,
    // output side
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [SAMPLE_W-1:0]    o_out_data,
    output logic                   o_out_last,
    // controller link
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status
);

    // request registers (payload, no reset)
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_second;
    logic                r_strong;
    logic [LEN_W-1:0]    r_len1;
    logic [LEN_W-1:0]    r_len2;

    // configuration and positions
    logic [FLEN_W-1:0]   r_fade_len;
    logic [STEP_W-1:0]   r_fade_step;
    logic [LEN_W-1:0]    r_pos1;
    logic [LEN_W-1:0]    r_pos2;

    // mix pipeline
    logic [STEP_W-1:0]   r_t;
    logic                r_last;
    logic signed [34:0]  r_prod;

    // output register
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;
    logic                r_out_last;

    logic [LEN_W-1:0]    w_flen;
    logic                w_fade;
    logic [LEN_W-1:0]    w_tail_start;
    logic [LEN_W-1:0]    w_tail_idx;
    logic                w_to_tail;
    logic                w_last1;
    logic                w_last2;
    logic                w_last;
    logic                w_drop;
    logic                w_mix;
    logic [27:0]         w_tprod;
    logic [STEP_W-1:0]   w_t;
    logic [SAMPLE_W-1:0] w_held;
    logic signed [16:0]  w_diff;
    logic signed [34:0]  w_prod;
    logic signed [35:0]  w_sum;
    logic                w_out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_len  <= '0;
            r_fade_step <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FADE_LENGTH: r_fade_len  <= i_cfg_data[FLEN_W-1:0];
                REG_FADE_STEP:   r_fade_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_tdata[15:0];
            r_len1   <= i_tdata[39:16];
            r_len2   <= i_tdata[63:40];
            r_second <= i_tuser[0];
            r_strong <= i_tuser[1];
        end
    end

    // fade decision and position checks
    assign w_flen       = LEN_W'(r_fade_len);
    assign w_fade       = (r_fade_len != '0) && (32'(r_fade_len) <= ACJ_MAX_FADE) &&
                          !r_strong && (r_len1 >= w_flen) && (r_len2 >= w_flen);
    assign w_tail_start = r_len1 - w_flen;
    assign w_tail_idx   = r_pos1 - w_tail_start;
    assign w_to_tail    = w_fade && (r_pos1 >= w_tail_start);
    assign w_last1      = (r_len2 == '0) && (r_pos1 == r_len1 - 1'b1);
    assign w_last2      = (r_pos2 == r_len2 - 1'b1);
    assign w_last       = r_second ? w_last2 : w_last1;
    assign w_drop       = r_second ? (r_pos2 >= r_len2) : (r_pos1 >= r_len1);
    assign w_mix        = w_fade && (r_pos2 < w_flen) && (r_fade_len != FLEN_W'(1));

    // ramp value t = q * step, saturated at 1.0
    assign w_tprod = 28'(r_pos2[FLEN_W-1:0]) * 28'(r_fade_step);
    assign w_t     = (w_tprod > 28'(ONE_Q16)) ? ONE_Q16 : w_tprod[STEP_W-1:0];

    // position update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos1 <= '0;
            r_pos2 <= '0;
        end else if (i_cmd.eval && !w_drop) begin
            if (w_last) begin
                r_pos1 <= '0;
                r_pos2 <= '0;
            end else if (r_second) begin
                r_pos2 <= r_pos2 + 1'b1;
            end else begin
                r_pos1 <= r_pos1 + 1'b1;
            end
        end
    end

    // tail buffer
    acj_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (ACJ_MAX_FADE)
    ) u_tail (
        .i_clk   (i_clk),
        .i_we    (i_cmd.eval && !w_drop && !r_second && w_to_tail),
        .i_waddr (w_tail_idx[ACJ_ADDR_W-1:0]),
        .i_wdata (r_sample),
        .i_re    (i_cmd.eval && r_second && w_mix),
        .i_raddr (r_pos2[ACJ_ADDR_W-1:0]),
        .o_rdata (w_held)
    );

    // mix: held + (cur - held) * t, rounded
    assign w_diff = $signed({r_sample[15], r_sample}) - $signed({w_held[15], w_held});
    assign w_prod = w_diff * $signed({1'b0, r_t});
    assign w_sum  = $signed({{4{w_held[15]}}, w_held, 16'b0}) + 36'(r_prod) +
                    36'sd32768;

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_t    <= w_t;
            r_last <= w_last;
        end
        if (i_cmd.mix_mult) begin
            r_prod <= w_prod;
        end
    end

    // output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out_direct || i_cmd.load_out_mix) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out_direct) begin
            r_out_data <= r_sample;
            r_out_last <= w_last;
        end else if (i_cmd.load_out_mix) begin
            r_out_data <= w_sum[31:16];
            r_out_last <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    assign o_status.drop     = w_drop;
    assign o_status.to_tail  = !r_second && w_to_tail;
    assign o_status.do_mix   = r_second && w_mix;
    assign o_status.out_free = w_out_free;

endmodule

### rtl/acj_ctrl.sv
// acj_ctrl: controller of the crossfade joiner, sequencing one request
// through evaluation and the two mix stages. Depends on acj_pkg.
module acj_ctrl
    import acj_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_MIX1 = 2'd2;
    localparam logic [1:0] ST_MIX2 = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.drop || i_status.to_tail) begin
                    o_cmd.eval = 1'b1;
                    n_state    = ST_IDLE;
                end else if (i_status.do_mix) begin
                    o_cmd.eval = 1'b1;
                    n_state    = ST_MIX1;
                end else if (i_status.out_free) begin
                    o_cmd.eval            = 1'b1;
                    o_cmd.load_out_direct = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            ST_MIX1: begin
                o_cmd.mix_mult = 1'b1;
                n_state        = ST_MIX2;
            end
            ST_MIX2: begin
                if (i_status.out_free) begin
                    o_cmd.load_out_mix = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/audio_crossfade_joiner_unit.sv
// audio_crossfade_joiner_unit: top level of the crossfade joiner.
// Depends on acj_pkg, acj_ctrl, acj_dp (and acj_ram through acj_dp).
//
// Usage:
//   Samples of the first segment, then of the second, enter on the slave
//   stream; each request carries both segment lengths and the boundary flag.
//   With a fade active, the last fade_length samples of the first segment are
//   held in a 1024-entry tail RAM and give no output; the head of the second
//   segment is mixed with them along a linear ramp. Samples beyond their
//   segment are dropped. tlast marks the final sample of the join.
//   Configuration (fade_length at index 0, fade_step at index 1) is written by the
//   user on its own always-ready channel only while idle; the block does not check it.
// Timing:
//   One request at a time. A dropped, buffered or pass-through sample is
//   accepted and evaluated; a mixed sample then goes through the mix-multiply
//   and mix-output states, as the tail RAM read and the ramp multiply are registered.
//   The result is loaded into the output register once that register is free.
// Reset (synchronous, active low) clears both positions, the configuration
//   and the output valid; the tail RAM is not cleared.
// Stall: the output register holds its result; the next request is still
//   accepted and processed up to the point where it needs the output.
module audio_crossfade_joiner_unit
    import acj_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // slave stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [TDATA_W-1:0]   i_s_axis_tdata,  // sample, first_length, second_length
    input  logic [TUSER_W-1:0]   i_s_axis_tuser,  // from_second, strong_boundary
    // master stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [SAMPLE_W-1:0]  o_m_axis_tdata,  // mixed_sample
    output logic                 o_m_axis_tlast   // last_of_join
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    // controller
    acj_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath
    acj_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tdata     (i_s_axis_tdata),
        .i_tuser     (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule
